/* hdl/acfe_pkg.sv */
// Shared types, constants and frame codes for the actuator command frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package acfe_pkg;

    localparam int VAL_W       = 32;
    localparam int RANGE_W     = 2 * VAL_W;
    localparam int FRAME_W     = 64;
    localparam int ID_W        = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_BITS    = 16;
    localparam int GAIN_BITS   = 12;
    localparam int QUO_W       = POS_BITS;
    localparam int DIVIDEND_W  = VAL_W + QUO_W;
    localparam int PREP_STAGES = 3;
    localparam int DIV_STAGES  = QUO_W;
    localparam int PIPE_DEPTH  = 1 + PREP_STAGES + DIV_STAGES;
    localparam int NUM_RANGES  = 5;

    typedef enum logic [1:0] {
        OP_MOVE    = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_ZERO    = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRQ_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KP_RANGE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_RANGE  = 3'd5;

    localparam int RNG_POS = 0;
    localparam int RNG_VEL = 1;
    localparam int RNG_TRQ = 2;
    localparam int RNG_KP  = 3;
    localparam int RNG_KD  = 4;

    localparam logic [FRAME_W-1:0] FRAME_ENABLE  = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [FRAME_W-1:0] FRAME_DISABLE = 64'hFFFF_FFFF_FFFF_FFFD;
    localparam logic [FRAME_W-1:0] FRAME_ZERO    = 64'hFFFF_FFFF_FFFF_FFFE;

endpackage

`default_nettype wire

/* hdl/acfe_prep.sv */
// Three-stage clamp, offset and scale of one Q16.16 value ahead of the divider.
`timescale 1ns / 1ps
`default_nettype none

module acfe_prep #(
    parameter int BITS = acfe_pkg::GAIN_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]   i_value,
    input  wire logic [acfe_pkg::RANGE_W-1:0]        i_range,
    output logic [acfe_pkg::DIVIDEND_W-1:0]          o_dividend,
    output logic [acfe_pkg::VAL_W-1:0]               o_span
);

    localparam int W = acfe_pkg::VAL_W;

    logic signed [W-1:0] w_lo;
    logic signed [W-1:0] w_hi;
    logic                w_ok;
    logic signed [W-1:0] w_vc;
    logic [W:0]          w_span;
    logic [W:0]          w_diff;

    logic signed [W-1:0] r1_vc;
    logic signed [W-1:0] r1_lo;
    logic [W-1:0]        r1_span;
    logic                r1_ok;
    logic [W-1:0]        r2_num;
    logic [W-1:0]        r2_span;
    logic [acfe_pkg::DIVIDEND_W-1:0] r3_dividend;
    logic [W-1:0]        r3_span;

    always_comb begin
        w_lo   = $signed(i_range[W-1:0]);
        w_hi   = $signed(i_range[2*W-1:W]);
        w_ok   = w_hi > w_lo;
        if (i_value > w_hi) begin
            w_vc = w_hi;
        end else if (i_value < w_lo) begin
            w_vc = w_lo;
        end else begin
            w_vc = i_value;
        end
        w_span = {w_hi[W-1], w_hi} - {w_lo[W-1], w_lo};
        w_diff = {r1_vc[W-1], r1_vc} - {r1_lo[W-1], r1_lo};
    end

    // empty range: zero numerator over a unit span gives code 0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vc       <= w_vc;
            r1_lo       <= w_lo;
            r1_ok       <= w_ok;
            r1_span     <= w_ok ? w_span[W-1:0] : {{(W-1){1'b0}}, 1'b1};
            r2_num      <= r1_ok ? w_diff[W-1:0] : '0;
            r2_span     <= r1_span;
            r3_dividend <= ({{acfe_pkg::QUO_W{1'b0}}, r2_num} << BITS)
                         - {{acfe_pkg::QUO_W{1'b0}}, r2_num};
            r3_span     <= r2_span;
        end
    end

    assign o_dividend = r3_dividend;
    assign o_span     = r3_span;

endmodule

`default_nettype wire

/* hdl/acfe_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module acfe_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [acfe_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  wire logic [acfe_pkg::VAL_W-1:0]          i_span,
    output logic [acfe_pkg::QUO_W-1:0]               o_quotient
);

    localparam int W  = acfe_pkg::VAL_W;
    localparam int QW = acfe_pkg::QUO_W;
    localparam int NS = acfe_pkg::DIV_STAGES;

    logic [W-1:0]  r_rem  [NS];
    logic [QW-1:0] r_low  [NS];
    logic [W-1:0]  r_span [NS];
    logic [QW-1:0] r_quo  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [W-1:0]  w_rem_in;
        logic [QW-1:0] w_low_in;
        logic [W-1:0]  w_span_in;
        logic [QW-1:0] w_quo_in;
        logic [W:0]    w_trial;
        logic [W:0]    w_sub;
        logic          w_ge;

        if (k == 0) begin : g_first
            // quotient fits QW bits, so the top part is already below the span
            assign w_rem_in  = i_dividend[acfe_pkg::DIVIDEND_W-1:QW];
            assign w_low_in  = i_dividend[QW-1:0];
            assign w_span_in = i_span;
            assign w_quo_in  = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_low_in  = r_low[k-1];
            assign w_span_in = r_span[k-1];
            assign w_quo_in  = r_quo[k-1];
        end

        always_comb begin
            w_trial = {w_rem_in, w_low_in[QW-1]};
            w_sub   = w_trial - {1'b0, w_span_in};
            w_ge    = w_trial >= {1'b0, w_span_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_sub[W-1:0] : w_trial[W-1:0];
                r_low[k]  <= {w_low_in[QW-2:0], 1'b0};
                r_span[k] <= w_span_in;
                r_quo[k]  <= {w_quo_in[QW-2:0], w_ge};
            end
        end
    end

    assign o_quotient = r_quo[NS-1];

endmodule

`default_nettype wire

/* hdl/actuator_command_frame_encoder.sv */
// Top level: config registers, five scaling lanes, frame packing and output register.
// An accepted input beat reaches its output beat through the input register, three
// clamp/scale stages, sixteen divider stages and the output register.
// Throughput: one beat per cycle; an output stall freezes the whole pipeline.
// Reset clears the config registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module actuator_command_frame_encoder (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [acfe_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [acfe_pkg::RANGE_W-1:0]          i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_op,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]     i_target_position,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]     i_target_velocity,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]     i_feedforward_torque,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]     i_stiffness_gain,
    input  wire logic signed [acfe_pkg::VAL_W-1:0]     i_damping_gain,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [acfe_pkg::ID_W-1:0]                  o_can_id,
    output logic [acfe_pkg::FRAME_W-1:0]               o_frame
);

    localparam int NR = acfe_pkg::NUM_RANGES;
    localparam int PD = acfe_pkg::PIPE_DEPTH;
    localparam int GB = acfe_pkg::GAIN_BITS;

    logic [acfe_pkg::ID_W-1:0]    r_motor_id;
    logic [acfe_pkg::RANGE_W-1:0] r_range [NR];

    logic                w_adv;
    logic                r_vld [PD];
    acfe_pkg::t_op       r_op  [PD];
    logic signed [acfe_pkg::VAL_W-1:0] r_val [NR];

    logic [acfe_pkg::DIVIDEND_W-1:0] w_dividend [NR];
    logic [acfe_pkg::VAL_W-1:0]      w_span     [NR];
    logic [acfe_pkg::QUO_W-1:0]      w_quo      [NR];

    logic                         r_out_valid;
    logic [acfe_pkg::ID_W-1:0]    r_can_id;
    logic [acfe_pkg::FRAME_W-1:0] r_frame;
    logic [acfe_pkg::FRAME_W-1:0] n_frame;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id <= '0;
            for (int i = 0; i < NR; i++) begin
                r_range[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acfe_pkg::REG_MOTOR_ID:  r_motor_id <= i_cfg_data[acfe_pkg::ID_W-1:0];
                acfe_pkg::REG_POS_RANGE: r_range[acfe_pkg::RNG_POS] <= i_cfg_data;
                acfe_pkg::REG_VEL_RANGE: r_range[acfe_pkg::RNG_VEL] <= i_cfg_data;
                acfe_pkg::REG_TRQ_RANGE: r_range[acfe_pkg::RNG_TRQ] <= i_cfg_data;
                acfe_pkg::REG_KP_RANGE:  r_range[acfe_pkg::RNG_KP]  <= i_cfg_data;
                acfe_pkg::REG_KD_RANGE:  r_range[acfe_pkg::RNG_KD]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid and op travel alongside the lane data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PD; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < PD; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_valid <= r_vld[PD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op[0] <= acfe_pkg::t_op'(i_op);
            for (int i = 1; i < PD; i++) begin
                r_op[i] <= r_op[i-1];
            end
            r_val[acfe_pkg::RNG_POS] <= i_target_position;
            r_val[acfe_pkg::RNG_VEL] <= i_target_velocity;
            r_val[acfe_pkg::RNG_TRQ] <= i_feedforward_torque;
            r_val[acfe_pkg::RNG_KP]  <= i_stiffness_gain;
            r_val[acfe_pkg::RNG_KD]  <= i_damping_gain;
            r_can_id <= r_motor_id;
            r_frame  <= n_frame;
        end
    end

    for (genvar l = 0; l < NR; l++) begin : g_lane
        localparam int LB = (l == acfe_pkg::RNG_POS) ? acfe_pkg::POS_BITS : GB;

        acfe_prep #(
            .BITS (LB)
        ) u_prep (
            .i_clk      (i_clk),
            .i_en       (w_adv),
            .i_value    (r_val[l]),
            .i_range    (r_range[l]),
            .o_dividend (w_dividend[l]),
            .o_span     (w_span[l])
        );

        acfe_div u_div (
            .i_clk      (i_clk),
            .i_en       (w_adv),
            .i_dividend (w_dividend[l]),
            .i_span     (w_span[l]),
            .o_quotient (w_quo[l])
        );
    end

    always_comb begin
        case (r_op[PD-1])
            acfe_pkg::OP_MOVE: begin
                n_frame = {w_quo[acfe_pkg::RNG_POS],
                           w_quo[acfe_pkg::RNG_VEL][GB-1:0],
                           w_quo[acfe_pkg::RNG_KP][GB-1:0],
                           w_quo[acfe_pkg::RNG_KD][GB-1:0],
                           w_quo[acfe_pkg::RNG_TRQ][GB-1:0]};
            end
            acfe_pkg::OP_ENABLE:  n_frame = acfe_pkg::FRAME_ENABLE;
            acfe_pkg::OP_DISABLE: n_frame = acfe_pkg::FRAME_DISABLE;
            acfe_pkg::OP_ZERO:    n_frame = acfe_pkg::FRAME_ZERO;
            default:              n_frame = acfe_pkg::FRAME_ZERO;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_can_id = r_can_id;
    assign o_frame  = r_frame;

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_vld[PD-1]) && $stable(r_op[PD-1]) && $stable(o_frame)))
        else $error("pipeline moved during output stall");

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[PD-1]) |=> o_valid)
        else $error("last stage beat lost on its way to the output");

    a_fixed_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[PD-1] && r_op[PD-1] != acfe_pkg::OP_MOVE)
        |=> (o_frame[acfe_pkg::FRAME_W-1:2] == '1))
        else $error("fixed command frame malformed");

endmodule

`default_nettype wire
